[hw/rtl/lzwc_pkg.sv]
// LZW compressor package: sequencer state type and fixed constants.
// No dependencies; imported by lzw_compressor_unit.
package lzwc_pkg;

	localparam int BYTE_BITS    = 8;
	localparam int SINGLE_CODES = 256;
	// Width of the per-stream mark kept in each hash slot.
	localparam int EPOCH_BITS   = 4;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_CMP,
		S_EMIT,
		S_FINAL
	} lzwc_state_t;

endpackage

[hw/rtl/lzw_compressor_unit.sv]
// LZW compressor top level: sequencer, hashed dictionary memory, output register.
// Depends on lzwc_pkg.
//
// LZW compressor taking one byte request at a time and returning 2^CODE_BITS-range
// codes. The dictionary is a hash table of 2*L slots, rounded up to a power of
// two (L = min(DICT_ENTRIES, 2^CODE_BITS)), in a single-port-read, single-port-write
// memory with linear probing; each slot holds a stream mark, the learned
// (prefix, byte) pair and its code. One compare unit checks one probed slot per
// cycle under a small sequencer: a byte that opens a stream only sets the prefix;
// any other byte probes from its hash slot until a hit or an empty slot, a miss
// emits a code, and the prefix is flushed as the final code at stream end; the
// output register lets a byte be taken while the last code still waits. Slots
// carry a stream mark instead of being erased at each stream end; after reset,
// and after every 15th stream when the mark wraps, a clearing pass writes every
// slot (8192 with the defaults) while in_ready stays low.
module lzw_compressor_unit #(
	parameter int DICT_ENTRIES = 4096,
	parameter int CODE_BITS    = 12
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [lzwc_pkg::BYTE_BITS-1:0] data_byte,
	input  logic                           stream_end,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [CODE_BITS-1:0]           code,
	output logic                           final_code
);
	import lzwc_pkg::*;

	// Dictionary limit and hash table geometry.
	localparam int DICT_LIMIT = (DICT_ENTRIES < (2 ** CODE_BITS)) ? DICT_ENTRIES
		: (2 ** CODE_BITS);
	localparam int SLOT_BITS  = $clog2(DICT_LIMIT) + 1;
	localparam int NF_BITS    = CODE_BITS + 1;
	localparam logic [NF_BITS-1:0] LIMIT_NF  = NF_BITS'(DICT_LIMIT);
	localparam logic [NF_BITS-1:0] FIRST_NF  = NF_BITS'(SINGLE_CODES);
	localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = EPOCH_BITS'(1);

	typedef struct packed {
		logic [EPOCH_BITS-1:0] mark;
		logic [CODE_BITS-1:0]  pfx;
		logic [BYTE_BITS-1:0]  byt;
		logic [CODE_BITS-1:0]  cde;
	} slot_t;

	// Fold prefix and byte into a slot index; prefixes stay below the limit,
	// so the truncation of the prefix drops only zero bits.
	function automatic logic [SLOT_BITS-1:0] slot_hash(
		input logic [CODE_BITS-1:0] p,
		input logic [BYTE_BITS-1:0] b
	);
		logic [SLOT_BITS-1:0] pw;
		logic [SLOT_BITS-1:0] bw;
		pw = SLOT_BITS'(p);
		bw = SLOT_BITS'(b) << (SLOT_BITS - BYTE_BITS);
		return pw ^ bw ^ SLOT_BITS'(b);
	endfunction

	lzwc_state_t state_q, state_d;

	slot_t                 slot_mem [2 ** SLOT_BITS];
	slot_t                 rd_q;
	logic [SLOT_BITS-1:0]  rd_addr;
	logic                  wr_en;
	logic [SLOT_BITS-1:0]  wr_addr;
	slot_t                 wr_data;

	logic [CODE_BITS-1:0]  prefix_q;
	logic                  prefix_valid_q;
	logic [NF_BITS-1:0]    next_free_q;
	logic [EPOCH_BITS-1:0] epoch_q;
	logic [SLOT_BITS-1:0]  clr_idx_q;
	logic [SLOT_BITS-1:0]  probe_idx_q;
	logic [BYTE_BITS-1:0]  byte_q;
	logic                  last_q;

	logic                  out_valid_q;
	logic [CODE_BITS-1:0]  code_q;
	logic                  final_q;

	logic accept;
	logic out_free;
	logic slot_live;
	logic slot_hit;
	logic dict_room;
	logic load_out;
	logic probe_next;

	assign in_ready   = (state_q == S_IDLE);
	assign accept     = in_valid && in_ready;
	assign out_free   = !out_valid_q || out_ready;
	assign slot_live  = (rd_q.mark == epoch_q);
	assign slot_hit   = slot_live && (rd_q.pfx == prefix_q) && (rd_q.byt == byte_q);
	assign dict_room  = (next_free_q < LIMIT_NF);
	assign load_out   = ((state_q == S_EMIT) || (state_q == S_FINAL)) && out_free;
	assign probe_next = (state_q == S_CMP) && slot_live && !slot_hit;

	// Sequencer: next state and memory port control.
	always_comb begin
		state_d = state_q;
		rd_addr = probe_idx_q;
		wr_en   = 1'b0;
		wr_addr = probe_idx_q;
		wr_data = '{mark: epoch_q, pfx: prefix_q, byt: byte_q,
			cde: CODE_BITS'(next_free_q)};
		unique case (state_q)
			S_CLEAR: begin
				// Sweep every slot back to the unused mark.
				wr_en   = 1'b1;
				wr_addr = clr_idx_q;
				wr_data = '0;
				if (clr_idx_q == '1) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				rd_addr = slot_hash(prefix_q, data_byte);
				if (accept) begin
					if (!prefix_valid_q) begin
						state_d = stream_end ? S_FINAL : S_IDLE;
					end else begin
						state_d = S_CMP;
					end
				end
			end
			S_CMP: begin
				rd_addr = probe_idx_q + SLOT_BITS'(1);
				if (slot_hit) begin
					state_d = last_q ? S_FINAL : S_IDLE;
				end else if (!slot_live) begin
					// Empty slot ends the probe: learn the pair here if room is left.
					wr_en   = dict_room;
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					state_d = last_q ? S_FINAL : S_IDLE;
				end
			end
			S_FINAL: begin
				if (out_free) begin
					state_d = (epoch_q == '1) ? S_CLEAR : S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Dictionary memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_mem[wr_addr] <= wr_data;
		end
		rd_q <= slot_mem[rd_addr];
	end

	// Request payload and probe position.
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= data_byte;
			last_q <= stream_end;
		end
		if (accept || probe_next) begin
			probe_idx_q <= rd_addr;
		end
	end

	// Prefix, dictionary fill and stream mark.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q       <= '0;
			prefix_valid_q <= 1'b0;
			next_free_q    <= FIRST_NF;
			epoch_q        <= EPOCH_FIRST;
			clr_idx_q      <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_idx_q <= clr_idx_q + SLOT_BITS'(1);
					epoch_q   <= EPOCH_FIRST;
				end
				S_IDLE: begin
					if (accept && !prefix_valid_q) begin
						// First byte of a stream only opens the prefix.
						prefix_q       <= CODE_BITS'(data_byte);
						prefix_valid_q <= 1'b1;
					end
				end
				S_CMP: begin
					if (slot_hit) begin
						prefix_q <= rd_q.cde;
					end else if (!slot_live && dict_room) begin
						next_free_q <= next_free_q + NF_BITS'(1);
					end
				end
				S_EMIT: begin
					// Old prefix goes out now; restart from the byte.
					if (out_free) begin
						prefix_q <= CODE_BITS'(byte_q);
					end
				end
				S_FINAL: begin
					// Flush done: drop the prefix and retire this stream's slots.
					if (out_free) begin
						prefix_q       <= '0;
						prefix_valid_q <= 1'b0;
						next_free_q    <= FIRST_NF;
						epoch_q        <= epoch_q + EPOCH_BITS'(1);
						clr_idx_q      <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Output register: holds a code until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			code_q  <= prefix_q;
			final_q <= (state_q == S_FINAL);
		end
	end

	assign out_valid  = out_valid_q;
	assign code       = code_q;
	assign final_code = final_q;

	// Fill never passes the limit.
	a_fill_limit: assert property (@(posedge clk) disable iff (!arst_n)
		next_free_q <= LIMIT_NF)
		else $error("next free code beyond dictionary limit");

	// With no pending prefix the dictionary holds no learned codes.
	a_empty_dict: assert property (@(posedge clk) disable iff (!arst_n)
		!prefix_valid_q |-> (next_free_q == FIRST_NF))
		else $error("learned codes present without a prefix");

	// A hit always returns a learned code of the current stream.
	a_hit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP && slot_hit) |->
			(NF_BITS'(rd_q.cde) >= FIRST_NF && NF_BITS'(rd_q.cde) < next_free_q))
		else $error("hit on a code outside the learned range");

	// Issuing the final code returns the stream state to reset.
	a_flush_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINAL && out_free) |=>
			(!prefix_valid_q && next_free_q == FIRST_NF && out_valid_q && final_q))
		else $error("flush did not reset the stream state");

	// No request is taken during the clearing pass.
	a_clear_block: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !in_ready)
		else $error("input ready during clearing pass");

endmodule
